// File: rtl/rcgm_pkg.sv
// Shared types, constants and the clock-to-gate-bit table of the clock gate manager.
// Used by every module of the block; depends on nothing else.
package rcgm_pkg;

	localparam int NUM_CLOCKS = 26;
	localparam int GATE_REGS  = 4;
	localparam int OUT_WORDS  = 4;
	localparam int TABLE_SIZE = 32;
	localparam int ID_W       = 5;
	localparam int CNT_W      = 8;
	localparam int IDX_W      = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
	localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;
	localparam logic [7:0] NO_REG = 8'hFF;

	typedef enum logic [1:0] {
		KIND_ENABLE  = 2'd0,
		KIND_DISABLE = 2'd1,
		KIND_QUERY   = 2'd2,
		KIND_INIT    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_SATURATED = 2'd2,
		ST_ZERO      = 2'd3
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   clock_id;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0]  use_count;
		logic              is_enabled;
		status_t           status;
		logic [31:0]       gate_word_a;
		logic [31:0]       gate_word_b;
		logic [31:0]       gate_word_c;
		logic [31:0]       gate_word_d;
	} rsp_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [CNT_W-1:0]  data;
	} cnt_wr_t;

	typedef logic [OUT_WORDS-1:0][31:0] gate_words_t;

	typedef struct packed {
		logic [7:0] widx;
		logic [4:0] bpos;
	} gate_map_t;

	localparam gate_map_t GATE_MAP [TABLE_SIZE] = '{
		'{8'd0, 5'd6},  '{8'd0, 5'd7},  '{8'd0, 5'd10}, '{8'd0, 5'd11},
		'{8'd0, 5'd12}, '{8'd0, 5'd18}, '{8'd0, 5'd19}, '{8'd0, 5'd22},
		'{8'd0, 5'd23}, '{8'd1, 5'd0},  '{8'd1, 5'd5},  '{8'd1, 5'd9},
		'{8'd1, 5'd10}, '{8'd1, 5'd11}, '{8'd1, 5'd12}, '{8'd1, 5'd13},
		'{8'd2, 5'd0},  '{8'd2, 5'd1},  '{8'd2, 5'd23}, '{8'd2, 5'd24},
		'{8'd2, 5'd25}, '{8'd2, 5'd26}, '{8'd2, 5'd27}, '{8'd2, 5'd29},
		'{8'd2, 5'd31}, '{8'd3, 5'd8},
		'{NO_REG, 5'd0}, '{NO_REG, 5'd0}, '{NO_REG, 5'd0},
		'{NO_REG, 5'd0}, '{NO_REG, 5'd0}, '{NO_REG, 5'd0}
	};

	function automatic logic has_gate_f(input logic [ID_W-1:0] id);
		return (GATE_MAP[id].widx < 8'(GATE_REGS));
	endfunction

	function automatic gate_words_t gate_words_f(input logic [NUM_CLOCKS-1:0] en);
		gate_words_t w;
		w = '0;
		for (int i = 0; i < NUM_CLOCKS; i++) begin
			if (en[i] && GATE_MAP[i].widx < 8'(GATE_REGS) && GATE_MAP[i].widx < 8'(OUT_WORDS)) begin
				w[GATE_MAP[i].widx[1:0]][GATE_MAP[i].bpos] = 1'b1;
			end
		end
		return w;
	endfunction

endpackage

// File: rtl/rcgm_count_store.sv
// Use count memory with a registered synchronous read, plus per-entry valid bits.
// Entries unwritten since reset read as zero, since init as the latched mask bit.
// Depends on rcgm_pkg.
module rcgm_count_store
	import rcgm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [CNT_W-1:0]      rd_count,
	input  cnt_wr_t               wr,
	input  logic                  init_en,
	input  logic [NUM_CLOCKS-1:0] init_mask
);

	logic [CNT_W-1:0]      mem [NUM_CLOCKS];
	logic [CNT_W-1:0]      rd_data_q;
	logic [IDX_W-1:0]      rd_addr_q;
	logic [NUM_CLOCKS-1:0] ld_q;
	logic [NUM_CLOCKS-1:0] base_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q   <= '0;
			base_q <= '0;
		end else if (init_en) begin
			ld_q   <= '0;
			base_q <= init_mask;
		end else if (wr.en) begin
			ld_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_count = ld_q[rd_addr_q] ? rd_data_q : {{(CNT_W-1){1'b0}}, base_q[rd_addr_q]};

endmodule

// File: rtl/rcgm_update.sv
// Read-modify-write logic for one request: new count, gate bits, status and response.
// Depends on rcgm_pkg.
module rcgm_update
	import rcgm_pkg::*;
(
	input  kind_t                 kind,
	input  logic [ID_W-1:0]       clock_id,
	input  logic [CNT_W-1:0]      count,
	input  logic [NUM_CLOCKS-1:0] en,
	input  logic [NUM_CLOCKS-1:0] mask,
	output cnt_wr_t               wr,
	output logic [NUM_CLOCKS-1:0] en_nxt,
	output rsp_t                  rsp
);

	logic             id_ok;
	logic [IDX_W-1:0] idx;
	logic [CNT_W-1:0] cnt_new;
	status_t          status;
	gate_words_t      words;

	assign id_ok = ({1'b0, clock_id} < (ID_W+1)'(NUM_CLOCKS));
	assign idx   = clock_id[IDX_W-1:0];

	always_comb begin
		en_nxt  = en;
		cnt_new = count;
		status  = ST_OK;
		wr.en   = 1'b0;
		wr.addr = idx;
		if (kind == KIND_INIT) begin
			en_nxt  = mask;
			cnt_new = id_ok ? {{(CNT_W-1){1'b0}}, mask[idx]} : '0;
		end else if (!id_ok) begin
			status = ST_INVALID;
		end else begin
			case (kind)
				KIND_ENABLE: begin
					if (count == COUNT_MAX) begin
						status = ST_SATURATED;
					end else begin
						cnt_new     = CNT_W'(count + 1'b1);
						wr.en       = 1'b1;
						en_nxt[idx] = 1'b1;
					end
				end
				KIND_DISABLE: begin
					if (count == '0) begin
						status = ST_ZERO;
					end else begin
						cnt_new     = CNT_W'(count - 1'b1);
						wr.en       = 1'b1;
						en_nxt[idx] = (count != CNT_W'(1));
					end
				end
				default: begin
				end
			endcase
		end
		wr.data = cnt_new;
	end

	assign words = gate_words_f(en_nxt);

	always_comb begin
		rsp.use_count   = id_ok ? cnt_new : '0;
		rsp.is_enabled  = id_ok && has_gate_f(clock_id) && en_nxt[idx];
		rsp.status      = status;
		rsp.gate_word_a = words[0];
		rsp.gate_word_b = words[1];
		rsp.gate_word_c = words[2];
		rsp.gate_word_d = words[3];
	end

endmodule

// File: rtl/refcounted_clock_gate_manager.sv
// Top level of the reference-counted clock gate manager.
// Depends on rcgm_pkg, rcgm_count_store and rcgm_update.
//
// Each request is handled in two steps: the first reads the use count from the count
// memory, whose read port is registered, and the second modifies it, writes it back
// and loads the response register; the second step waits while a response is stalled.
// A new request is taken once the previous one has been written back, so requests
// do not overlap. Gate bits live in flip-flops. Init takes effect through per-entry
// valid bits, so there is no clearing pass after reset or init. The default mask may
// be written only while no request is in flight.
module refcounted_clock_gate_manager
	import rcgm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [NUM_CLOCKS-1:0] cfg_data
);

	logic                  busy_q;
	kind_t                 kind_s1;
	logic [ID_W-1:0]       id_s1;
	logic [NUM_CLOCKS-1:0] mask_q;
	logic [NUM_CLOCKS-1:0] en_q;
	logic [NUM_CLOCKS-1:0] en_nxt;
	logic                  accept;
	logic                  complete;
	logic                  rd_en;
	logic [CNT_W-1:0]      count;
	cnt_wr_t               upd_wr;
	cnt_wr_t               mem_wr;
	rsp_t                  upd_rsp;

	assign cfg_ready = 1'b1;
	assign req_stall = busy_q;
	assign accept    = req_valid && !req_stall;
	assign complete  = busy_q && (!rsp_valid || !rsp_stall);
	assign rd_en     = accept && ({1'b0, req.clock_id} < (ID_W+1)'(NUM_CLOCKS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rsp_valid <= 1'b0;
			en_q      <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (complete) begin
				busy_q <= 1'b0;
			end
			if (complete) begin
				rsp_valid <= 1'b1;
				en_q      <= en_nxt;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= req.kind;
			id_s1   <= req.clock_id;
		end
		if (complete) begin
			rsp <= upd_rsp;
		end
	end

	always_comb begin
		mem_wr    = upd_wr;
		mem_wr.en = upd_wr.en && complete;
	end

	rcgm_count_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_addr   (req.clock_id[IDX_W-1:0]),
		.rd_count  (count),
		.wr        (mem_wr),
		.init_en   (complete && kind_s1 == KIND_INIT),
		.init_mask (mask_q)
	);

	rcgm_update u_update (
		.kind     (kind_s1),
		.clock_id (id_s1),
		.count    (count),
		.en       (en_q),
		.mask     (mask_q),
		.wr       (upd_wr),
		.en_nxt   (en_nxt),
		.rsp      (upd_rsp)
	);

	a_init_loads_mask: assert property (@(posedge clk) disable iff (!arst_n)
		complete && kind_s1 == KIND_INIT |=> en_q == $past(mask_q))
		else $error("gate bits differ from the default mask after init");

	a_query_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		complete && kind_s1 == KIND_QUERY && has_gate_f(id_s1) |=>
		rsp.is_enabled == (rsp.use_count != '0))
		else $error("gate bit disagrees with the use count");

	a_saturated_count: assert property (@(posedge clk) disable iff (!arst_n)
		complete && upd_rsp.status == ST_SATURATED |=> rsp.use_count == COUNT_MAX)
		else $error("saturated status without a full count");

	a_no_write_on_init: assert property (@(posedge clk) disable iff (!arst_n)
		complete && kind_s1 == KIND_INIT |-> !mem_wr.en)
		else $error("count memory written during init");

endmodule

// File: bench/tb.sv
// Testbench for the reference-counted clock gate manager: directed script, then random traffic.
// Depends on rcgm_pkg and refcounted_clock_gate_manager; responses are checked against a local model.
`timescale 1ns / 100ps

module tb;
	import rcgm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int PRINT_CAP = 40;
	localparam int MAP_WORD [NUM_CLOCKS] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1,
		1, 1, 1, 2, 2, 2, 2, 2, 2, 2, 2, 2, 3};
	localparam int MAP_BIT [NUM_CLOCKS] = '{6, 7, 10, 11, 12, 18, 19, 22, 23, 0, 5, 9, 10,
		11, 12, 13, 0, 1, 23, 24, 25, 26, 27, 29, 31, 8};

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             en;
		status_t          st;
		logic             pinned;
	} pin_t;

	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] id;
		logic [8:0]      reps;
		pin_t            pin;
	} script_row_t;

	localparam int SCRIPT_LEN = 20;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{KIND_QUERY,   5'd0,  9'd1,   '{8'd0,   1'b0, ST_OK,        1'b1}},
		'{KIND_DISABLE, 5'd0,  9'd1,   '{8'd0,   1'b0, ST_ZERO,      1'b1}},
		'{KIND_ENABLE,  5'd0,  9'd1,   '{8'd1,   1'b1, ST_OK,        1'b1}},
		'{KIND_ENABLE,  5'd0,  9'd1,   '{8'd2,   1'b1, ST_OK,        1'b1}},
		'{KIND_DISABLE, 5'd0,  9'd1,   '{8'd1,   1'b1, ST_OK,        1'b1}},
		'{KIND_DISABLE, 5'd0,  9'd1,   '{8'd0,   1'b0, ST_OK,        1'b1}},
		'{KIND_ENABLE,  5'd25, 9'd1,   '{8'd1,   1'b1, ST_OK,        1'b1}},
		'{KIND_QUERY,   5'd26, 9'd1,   '{8'd0,   1'b0, ST_INVALID,   1'b1}},
		'{KIND_ENABLE,  5'd31, 9'd1,   '{8'd0,   1'b0, ST_INVALID,   1'b1}},
		'{KIND_DISABLE, 5'd30, 9'd1,   '{8'd0,   1'b0, ST_INVALID,   1'b1}},
		'{KIND_INIT,    5'd31, 9'd1,   '{8'd0,   1'b0, ST_OK,        1'b1}},
		'{KIND_QUERY,   5'd25, 9'd1,   '{8'd1,   1'b1, ST_OK,        1'b1}},
		'{KIND_DISABLE, 5'd25, 9'd1,   '{8'd0,   1'b0, ST_OK,        1'b1}},
		'{KIND_QUERY,   5'd13, 9'd1,   '{8'd1,   1'b1, ST_OK,        1'b1}},
		'{KIND_INIT,    5'd0,  9'd1,   '{8'd1,   1'b1, ST_OK,        1'b1}},
		'{KIND_ENABLE,  5'd24, 9'd254, '{8'd0,   1'b0, ST_OK,        1'b0}},
		'{KIND_ENABLE,  5'd24, 9'd1,   '{8'd255, 1'b1, ST_SATURATED, 1'b1}},
		'{KIND_DISABLE, 5'd24, 9'd1,   '{8'd254, 1'b1, ST_OK,        1'b1}},
		'{KIND_ENABLE,  5'd7,  9'd1,   '{8'd0,   1'b0, ST_OK,        1'b0}},
		'{KIND_QUERY,   5'd24, 9'd1,   '{8'd0,   1'b0, ST_OK,        1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [NUM_CLOCKS-1:0] cfg_data = '0;

	logic [CNT_W-1:0] use_cnt [NUM_CLOCKS] = '{default: '0};
	logic [NUM_CLOCKS-1:0] dflt_mask = '0;
	rsp_t gate_expect_q [$];
	pin_t pinned_q [$];
	rsp_t want;
	pin_t pin;
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int masks_loaded = 0;
	int cycle_cnt = 0;
	int snd_pct = 0;
	int rcv_pct = 0;
	int hot_id [4];

	refcounted_clock_gate_manager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic rsp_t apply_request(req_t r);
		rsp_t p;
		logic [31:0] w [4];
		logic known;
		known = int'(r.clock_id) < NUM_CLOCKS;
		p = '0;
		p.status = ST_OK;
		if (r.kind == KIND_INIT) begin
			for (int i = 0; i < NUM_CLOCKS; i++)
				use_cnt[i] = {{(CNT_W-1){1'b0}}, dflt_mask[i]};
		end else if (!known) begin
			p.status = ST_INVALID;
		end else if (r.kind == KIND_ENABLE) begin
			if (use_cnt[r.clock_id] == COUNT_MAX)
				p.status = ST_SATURATED;
			else
				use_cnt[r.clock_id] = use_cnt[r.clock_id] + 1'b1;
		end else if (r.kind == KIND_DISABLE) begin
			if (use_cnt[r.clock_id] == '0)
				p.status = ST_ZERO;
			else
				use_cnt[r.clock_id] = use_cnt[r.clock_id] - 1'b1;
		end
		w = '{default: '0};
		for (int i = 0; i < NUM_CLOCKS; i++)
			if (use_cnt[i] != '0)
				w[MAP_WORD[i]][MAP_BIT[i]] = 1'b1;
		if (known) begin
			p.use_count = use_cnt[r.clock_id];
			p.is_enabled = use_cnt[r.clock_id] != '0;
		end
		p.gate_word_a = w[0];
		p.gate_word_b = w[1];
		p.gate_word_c = w[2];
		p.gate_word_d = w[3];
		return p;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
		errors++;
		if (errors <= PRINT_CAP)
			$display("Mismatch in %s at response %0d: got %0h, expected %0h", field, checked,
				got, exp_val);
	endtask

	task automatic compare_response(rsp_t got, rsp_t exp_val);
		if (got.use_count !== exp_val.use_count)
			report_mismatch("use_count", 32'(got.use_count), 32'(exp_val.use_count));
		if (got.is_enabled !== exp_val.is_enabled)
			report_mismatch("is_enabled", 32'(got.is_enabled), 32'(exp_val.is_enabled));
		if (got.status !== exp_val.status)
			report_mismatch("status", 32'(got.status), 32'(exp_val.status));
		if (got.gate_word_a !== exp_val.gate_word_a)
			report_mismatch("gate_word_a", got.gate_word_a, exp_val.gate_word_a);
		if (got.gate_word_b !== exp_val.gate_word_b)
			report_mismatch("gate_word_b", got.gate_word_b, exp_val.gate_word_b);
		if (got.gate_word_c !== exp_val.gate_word_c)
			report_mismatch("gate_word_c", got.gate_word_c, exp_val.gate_word_c);
		if (got.gate_word_d !== exp_val.gate_word_d)
			report_mismatch("gate_word_d", got.gate_word_d, exp_val.gate_word_d);
	endtask

	// Responses are checked before new requests are recorded, so a response that arrives
	// with no transaction outstanding is never matched against one accepted at the same edge.
	always @(posedge clk) begin
		cycle_cnt++;
		if (arst_n) begin
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (gate_expect_q.size() == 0)
					report_mismatch("unrequested response", rsp[31:0], '0);
				else
					compare_response(rsp, gate_expect_q.pop_front());
				checked++;
			end
			if (cfg_valid && cfg_ready === 1'b1)
				dflt_mask = cfg_data;
			if (req_valid && req_stall === 1'b0) begin
				want = apply_request(req);
				pin = pinned_q.pop_front();
				if (pin.pinned) begin
					want.use_count = pin.cnt;
					want.is_enabled = pin.en;
					want.status = pin.st;
				end
				gate_expect_q.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		rsp_stall <= arst_n && ($urandom_range(99) < rcv_pct);
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send_request(req_t r, pin_t p);
		while ($urandom_range(99) < snd_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		pinned_q.push_back(p);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		sent++;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (gate_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_mask(logic [NUM_CLOCKS-1:0] m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		cfg_valid <= 1'b0;
		masks_loaded++;
	endtask

	function automatic req_t random_request();
		req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 42)
			r.kind = KIND_ENABLE;
		else if (pick < 78)
			r.kind = KIND_DISABLE;
		else if (pick < 96)
			r.kind = KIND_QUERY;
		else
			r.kind = KIND_INIT;
		if ($urandom_range(99) < 85)
			r.clock_id = ID_W'(hot_id[$urandom_range(3)]);
		else
			r.clock_id = ID_W'($urandom_range(31));
		return r;
	endfunction

	initial begin
		req_t r;
		logic [NUM_CLOCKS-1:0] m;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_mask('1);
		foreach (SCRIPT[k]) begin
			r.kind = SCRIPT[k].kind;
			r.clock_id = SCRIPT[k].id;
			for (int n = 0; n < SCRIPT[k].reps; n++)
				send_request(r, SCRIPT[k].pin);
		end
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					snd_pct = 0;
					rcv_pct = 0;
					m = '0;
				end
				1: begin
					snd_pct = 54;
					rcv_pct = 0;
					m = '1;
				end
				2: begin
					snd_pct = 0;
					rcv_pct = 54;
					m = NUM_CLOCKS'($urandom());
				end
				default: begin
					snd_pct = 34;
					rcv_pct = 34;
					m = NUM_CLOCKS'($urandom());
				end
			endcase
			load_mask(m);
			foreach (hot_id[j])
				hot_id[j] = $urandom_range(NUM_CLOCKS - 1);
			r.kind = KIND_INIT;
			r.clock_id = ID_W'($urandom_range(31));
			send_request(r, '0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_request(random_request(), '0);
			settle();
		end

		$display("Sent %0d requests and checked %0d responses under %0d default masks,", sent,
			checked, masks_loaded);
		$display("with back-to-back traffic, sender gaps, receiver stalls and both combined.");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: refcounted_clock_gate_manager.f
rtl/rcgm_pkg.sv
rtl/rcgm_count_store.sv
rtl/rcgm_update.sv
rtl/refcounted_clock_gate_manager.sv
bench/tb.sv
